@@ design/tst_pkg.sv @@
// timer_slot_table package: opcodes, flag actions, controller command/status types
// used by tst_ctrl, tst_dp and timer_slot_table
package tst_pkg;

  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_KILL = 2'd1;
  localparam logic [1:0] OP_POLL = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  localparam logic [1:0] FLAG_NONE  = 2'd0;
  localparam logic [1:0] FLAG_SET   = 2'd1;
  localparam logic [1:0] FLAG_CLEAR = 2'd2;

  localparam logic [30:0] DEFAULT_INTERVAL_RESET = 31'd20;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_READ  = 7'b0000010,
    ST_EVAL  = 7'b0000100,
    ST_STEP  = 7'b0001000,
    ST_EMIT  = 7'b0010000,
    ST_HIGH  = 7'b0100000,
    ST_HEVAL = 7'b1000000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input transaction, reset scan
    logic reduce;    // subtract highest_slot+1 from a stale poll start index
    logic rd;        // read slot at scan index
    logic eval;      // evaluate read slot, may write
    logic step;      // advance scan index
    logic emit_slot; // emit tick expiry result
    logic emit_fin;  // emit final result
    logic hread;     // read slot at highest_slot for shrink
    logic heval;     // evaluate shrink step
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       hit;       // slot matched (set/kill/poll) or expired (tick)
    logic       wrap;      // poll start index is above highest_slot
    logic       scan_done; // current index is the last one to visit
    logic       shrink;    // kill freed highest slot and it is nonzero
    logic       hstop;     // shrink walk reached an owned slot or zero
    logic       out_busy;  // output register holds an untaken result
  } stat_t;

endpackage

@@ design/tst_ctrl.sv @@
// timer_slot_table controller: sequences the slot scan of each operation
// depends on tst_pkg
module tst_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  tst_pkg::stat_t st,
  output tst_pkg::cmd_t  cmd
);

  tst_pkg::state_t state, state_next;

  assign in_stall = (state != tst_pkg::ST_IDLE) || st.out_busy;

  always_ff @(posedge clk) begin
    if (rst) state <= tst_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      tst_pkg::ST_IDLE: begin
        if (in_valid && !st.out_busy) begin
          cmd.load = 1'b1;
          state_next = tst_pkg::ST_READ;
        end
      end
      tst_pkg::ST_READ: begin
        // a stale poll offset is brought into range one subtraction per cycle
        if (st.wrap) cmd.reduce = 1'b1;
        else begin
          cmd.rd = 1'b1;
          state_next = tst_pkg::ST_EVAL;
        end
      end
      tst_pkg::ST_EVAL: begin
        if (st.op == tst_pkg::OP_TICK) begin
          if (st.hit) begin
            if (!st.out_busy) begin
              cmd.eval = 1'b1;
              cmd.emit_slot = 1'b1;
              state_next = tst_pkg::ST_STEP;
            end
          end else begin
            cmd.eval = 1'b1;
            state_next = tst_pkg::ST_STEP;
          end
        end else if (st.hit) begin
          cmd.eval = 1'b1;
          state_next = (st.op == tst_pkg::OP_KILL && st.shrink) ?
                       tst_pkg::ST_HIGH : tst_pkg::ST_EMIT;
        end else begin
          state_next = tst_pkg::ST_STEP;
        end
      end
      tst_pkg::ST_STEP: begin
        if (st.scan_done) state_next = tst_pkg::ST_EMIT;
        else begin
          cmd.step = 1'b1;
          state_next = tst_pkg::ST_READ;
        end
      end
      tst_pkg::ST_HIGH: begin
        cmd.hread = 1'b1;
        state_next = tst_pkg::ST_HEVAL;
      end
      tst_pkg::ST_HEVAL: begin
        cmd.heval = 1'b1;
        state_next = st.hstop ? tst_pkg::ST_EMIT : tst_pkg::ST_HIGH;
      end
      tst_pkg::ST_EMIT: begin
        if (!st.out_busy) begin
          cmd.emit_fin = 1'b1;
          state_next = tst_pkg::ST_IDLE;
        end
      end
      default: state_next = tst_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ design/tst_dp.sv @@
// timer_slot_table datapath: slot memories, owner valid bits, scan index, output register
// depends on tst_pkg
module tst_dp #(
  parameter int SLOTS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tst_pkg::cmd_t        cmd,
  output tst_pkg::stat_t       st,
  input  logic [30:0]          cfg_data,
  input  logic                 cfg_we,
  input  logic [1:0]           opcode,
  input  logic [15:0]          task_req,
  input  logic [15:0]          window,
  input  logic [15:0]          timer_id,
  input  logic [30:0]          interval,
  input  logic                 system_flag,
  input  logic [31:0]          callback,
  input  logic                 remove_flag,
  input  logic [30:0]          elapsed,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 ok,
  output logic [15:0]          result_id,
  output logic [15:0]          window_out,
  output logic                 system_out,
  output logic [31:0]          callback_out,
  output logic [1:0]           flag_action,
  output logic [15:0]          flag_task,
  output logic signed [31:0]   min_timeout,
  output logic                 last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // slot storage; owner has a valid bit per slot so reset frees all
  logic [SLOTS-1:0] owned;
  logic [15:0] mem_owner  [SLOTS];
  logic [15:0] mem_window [SLOTS];
  logic [15:0] mem_ident  [SLOTS];
  logic [30:0] mem_period [SLOTS];
  logic        mem_sys    [SLOTS];
  logic signed [31:0] mem_wait [SLOTS];
  logic [31:0] mem_cb     [SLOTS];

  logic [30:0] default_interval;
  logic [IW-1:0] highest_slot, scan_offset;

  // captured transaction
  logic [1:0]  op;
  logic [15:0] t_task, t_win, t_id;
  logic [30:0] t_per, t_el;
  logic        t_sys, t_rm;
  logic [31:0] t_cb;

  logic [IW-1:0] idx, cnt, last_cnt, found, first_idx;
  logic          found_v;
  logic signed [32:0] minv;

  // registered read of one slot
  logic          r_owned;
  logic [15:0]   r_owner, r_window, r_ident;
  logic [30:0]   r_period;
  logic          r_sys;
  logic signed [31:0] r_wait;
  logic [31:0]   r_cb;
  logic [IW-1:0] r_idx;

  logic [IW-1:0] rd_addr;
  assign rd_addr = cmd.hread ? highest_slot : idx;

  always_ff @(posedge clk) begin
    if (cmd.rd || cmd.hread) begin
      r_owned  <= owned[rd_addr];
      r_owner  <= mem_owner[rd_addr];
      r_window <= mem_window[rd_addr];
      r_ident  <= mem_ident[rd_addr];
      r_period <= mem_period[rd_addr];
      r_sys    <= mem_sys[rd_addr];
      r_wait   <= mem_wait[rd_addr];
      r_cb     <= mem_cb[rd_addr];
      r_idx    <= rd_addr;
    end
  end

  logic signed [32:0] tick_w;
  assign tick_w = {r_wait[31], r_wait} - $signed({2'b00, t_el});

  logic hit;
  always_comb begin
    case (op)
      tst_pkg::OP_SET:  hit = !r_owned && (t_task != '0);
      tst_pkg::OP_KILL: hit = r_owned && r_owner == t_task && r_window == t_win &&
                              r_ident == t_id;
      tst_pkg::OP_POLL: hit = r_owned && r_owner == t_task && r_wait <= 0 &&
                              (t_win == '0 || r_window == t_win);
      default:          hit = r_owned && tick_w <= 0;
    endcase
  end

  // poll start index after one subtraction of highest_slot+1
  logic [IW-1:0] wrap_idx;
  assign wrap_idx = idx - highest_slot - 1'b1;

  assign st.op        = op;
  assign st.hit       = hit && !(op == tst_pkg::OP_SET && t_task == '0);
  assign st.wrap      = (op == tst_pkg::OP_POLL) && (idx > highest_slot);
  assign st.scan_done = (cnt == last_cnt);
  assign st.shrink    = (r_idx == highest_slot) && (highest_slot != '0);
  assign st.hstop     = r_owned || (highest_slot == '0);
  assign st.out_busy  = out_valid;

  logic [15:0] set_id;
  assign set_id = (t_win == '0) ? 16'(r_idx + 1'b1) : t_id;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= opcode; t_task <= task_req; t_win <= window; t_id <= timer_id;
      t_per <= (interval == '0) ? default_interval : interval;
      t_sys <= system_flag; t_cb <= callback; t_rm <= remove_flag; t_el <= elapsed;
      cnt <= '0;
      found_v <= 1'b0;
      minv <= '0;
      first_idx <= scan_offset;
      if (opcode == tst_pkg::OP_POLL) begin
        idx <= scan_offset;
        last_cnt <= highest_slot;
      end else begin
        idx <= '0;
        last_cnt <= IW'(SLOTS - 1);
      end
    end
    if (cmd.reduce) begin
      idx <= wrap_idx;
      first_idx <= wrap_idx;
    end
    if (cmd.step) begin
      cnt <= cnt + 1'b1;
      if (op == tst_pkg::OP_POLL && idx == highest_slot) idx <= '0;
      else idx <= idx + 1'b1;
    end
    if (cmd.eval) begin
      found_v <= 1'b1;
      found <= r_idx;
      if (op == tst_pkg::OP_TICK && r_owned) begin
        if (tick_w <= 0) minv <= -33'sd1;
        else if (minv == 0 || (minv > 0 && tick_w < minv)) minv <= tick_w;
      end
    end
    if (cmd.eval && op == tst_pkg::OP_TICK && r_owned) begin
      mem_wait[r_idx] <= (tick_w <= 0) ? 32'sd0 : tick_w[31:0];
    end
    if (cmd.eval && op == tst_pkg::OP_SET) begin
      mem_owner[r_idx]  <= t_task;
      mem_window[r_idx] <= t_win;
      mem_ident[r_idx]  <= set_id;
      mem_period[r_idx] <= t_per;
      mem_sys[r_idx]    <= t_sys;
      mem_wait[r_idx]   <= {1'b0, t_per};
      mem_cb[r_idx]     <= t_cb;
    end
    if (cmd.eval && op == tst_pkg::OP_POLL && t_rm) begin
      mem_wait[r_idx] <= {1'b0, r_period};
    end
    if (rst) begin
      owned <= '0;
      highest_slot <= '0;
      scan_offset <= '0;
      default_interval <= tst_pkg::DEFAULT_INTERVAL_RESET;
    end else begin
      if (cfg_we) default_interval <= cfg_data;
      if (cmd.eval && op == tst_pkg::OP_SET) begin
        owned[r_idx] <= 1'b1;
        if (r_idx > highest_slot) highest_slot <= r_idx;
      end
      if (cmd.eval && op == tst_pkg::OP_KILL) begin
        owned[r_idx] <= 1'b0;
        if (st.shrink) highest_slot <= highest_slot - 1'b1;
      end
      if (cmd.heval && !st.hstop) highest_slot <= highest_slot - 1'b1;
      if (cmd.emit_fin && op == tst_pkg::OP_POLL)
        scan_offset <= (first_idx == highest_slot) ? '0 : first_idx + 1'b1;
    end
  end

  logic poll_found;
  assign poll_found = cmd.emit_fin && found_v && (op == tst_pkg::OP_POLL);

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit_slot || cmd.emit_fin) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (cmd.emit_slot || cmd.emit_fin) begin
      last <= cmd.emit_fin;
      ok <= cmd.emit_fin && (op != tst_pkg::OP_TICK) && found_v;
      if (cmd.emit_fin && found_v && op == tst_pkg::OP_SET)
        result_id <= (mem_ident[found] == '0) ? 16'd1 : mem_ident[found];
      else if (poll_found)
        result_id <= mem_ident[found];
      else
        result_id <= '0;
      window_out <= poll_found ? mem_window[found] : '0;
      system_out <= poll_found ? mem_sys[found] : 1'b0;
      callback_out <= poll_found ? mem_cb[found] : '0;
      if (cmd.emit_slot) begin
        flag_action <= tst_pkg::FLAG_SET;
        flag_task <= r_owner;
      end else if (op == tst_pkg::OP_POLL && !found_v) begin
        flag_action <= tst_pkg::FLAG_CLEAR;
        flag_task <= t_task;
      end else begin
        flag_action <= tst_pkg::FLAG_NONE;
        flag_task <= '0;
      end
      min_timeout <= (cmd.emit_fin && op == tst_pkg::OP_TICK) ? minv[31:0] : '0;
    end
  end

endmodule

@@ design/timer_slot_table.sv @@
// timer_slot_table: table of periodic timer slots (set, kill, poll, tick)
// scan: load, read/eval/step per visited slot, then emit; set/kill stop at the first match,
// poll visits up to highest_slot+1 slots (a stale scan offset adds one subtraction per wrap),
// tick visits all SLOTS, kill shrink adds hread/heval per step; a stalled result holds the scan
// throughput: one transaction at a time; reset (rst, synchronous): all slots free,
// highest slot and scan offset zero, default interval 20; depends on tst_pkg, tst_ctrl, tst_dp
module timer_slot_table #(
  parameter int SLOTS = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [30:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          opcode,
  input  logic [15:0]         task_req,
  input  logic [15:0]         window,
  input  logic [15:0]         timer_id,
  input  logic [30:0]         interval,
  input  logic                system_flag,
  input  logic [31:0]         callback,
  input  logic                remove_flag,
  input  logic [30:0]         elapsed,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                ok,
  output logic [15:0]         result_id,
  output logic [15:0]         window_out,
  output logic                system_out,
  output logic [31:0]         callback_out,
  output logic [1:0]          flag_action,
  output logic [15:0]         flag_task,
  output logic signed [31:0]  min_timeout,
  output logic                last
);

  tst_pkg::cmd_t  cmd;
  tst_pkg::stat_t st;

  assign cfg_ready = 1'b1;

  tst_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .st(st), .cmd(cmd)
  );

  tst_dp #(.SLOTS(SLOTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .cfg_data(cfg_data), .cfg_we(cfg_valid),
    .opcode(opcode), .task_req(task_req), .window(window), .timer_id(timer_id),
    .interval(interval), .system_flag(system_flag), .callback(callback),
    .remove_flag(remove_flag), .elapsed(elapsed),
    .out_valid(out_valid), .out_stall(out_stall), .ok(ok), .result_id(result_id),
    .window_out(window_out), .system_out(system_out), .callback_out(callback_out),
    .flag_action(flag_action), .flag_task(flag_task), .min_timeout(min_timeout),
    .last(last)
  );

endmodule

@@ tb/timer_slot_table_test.sv @@
// timer_slot_table_test: self-checking testbench for the timer slot table
// drives set/kill/poll/tick transactions, predicts results in a scoreboard class
// depends on tst_pkg and timer_slot_table
`timescale 1ns / 100ps

module timer_slot_table_test;

  localparam int NSLOT = 48;

  typedef struct {
    logic [1:0]  opcode;
    logic [15:0] task_req;
    logic [15:0] window;
    logic [15:0] timer_id;
    logic [30:0] interval;
    logic        system_flag;
    logic [31:0] callback;
    logic        remove_flag;
    logic [30:0] elapsed;
  } timer_req_t;

  typedef struct {
    logic               ok;
    logic [15:0]        result_id;
    logic [15:0]        window_out;
    logic               system_out;
    logic [31:0]        callback_out;
    logic [1:0]         flag_action;
    logic [15:0]        flag_task;
    logic signed [31:0] min_timeout;
    logic               last;
  } timer_resp_t;

  class timer_scoreboard;
    logic [30:0]        dflt_period;
    logic [15:0]        owner[NSLOT];
    logic [15:0]        win[NSLOT];
    logic [15:0]        ident[NSLOT];
    logic [30:0]        period[NSLOT];
    logic               sys[NSLOT];
    logic signed [31:0] remaining[NSLOT];
    logic [31:0]        cb[NSLOT];
    int                 top_slot;
    int                 scan_pos;
    timer_resp_t        expected_q[$];
    int                 errors;

    function void clear_state();
      dflt_period = tst_pkg::DEFAULT_INTERVAL_RESET;
      foreach (owner[i]) owner[i] = '0;
      top_slot = 0;
      scan_pos = 0;
      errors = 0;
    endfunction

    function timer_resp_t blank();
      timer_resp_t r;
      r = '{default: '0};
      return r;
    endfunction

    function void note_input(timer_req_t q);
      timer_resp_t r;
      int          m;
      int          idx;
      longint      w;
      longint      least;
      logic [30:0] per;
      r = blank();
      r.last = 1'b1;
      case (q.opcode)
        tst_pkg::OP_SET: begin
          if (q.task_req != 0) begin
            per = (q.interval == 0) ? dflt_period : q.interval;
            for (int n = 0; n < NSLOT; n++) begin
              if (owner[n] == 0) begin
                owner[n] = q.task_req;
                win[n] = q.window;
                ident[n] = (q.window == 0) ? 16'(n + 1) : q.timer_id;
                period[n] = per;
                sys[n] = q.system_flag;
                remaining[n] = {1'b0, per};
                cb[n] = q.callback;
                if (n > top_slot) top_slot = n;
                r.ok = 1'b1;
                r.result_id = (ident[n] != 0) ? ident[n] : 16'd1;
                break;
              end
            end
          end
          expected_q.push_back(r);
        end
        tst_pkg::OP_KILL: begin
          if (q.task_req != 0) begin
            for (int n = 0; n < NSLOT; n++) begin
              if (owner[n] == q.task_req && win[n] == q.window && ident[n] == q.timer_id) begin
                owner[n] = '0;
                if (top_slot != 0 && n == top_slot) begin
                  top_slot--;
                  while (top_slot != 0 && owner[top_slot] == 0) top_slot--;
                end
                r.ok = 1'b1;
                break;
              end
            end
          end
          expected_q.push_back(r);
        end
        tst_pkg::OP_POLL: begin
          m = top_slot + 1;
          for (int n = 0; n < m; n++) begin
            idx = (n + scan_pos) % m;
            if (owner[idx] != 0 && owner[idx] == q.task_req && remaining[idx] <= 0 &&
                (q.window == 0 || win[idx] == q.window)) begin
              r.ok = 1'b1;
              r.result_id = ident[idx];
              r.window_out = win[idx];
              r.system_out = sys[idx];
              r.callback_out = cb[idx];
              if (q.remove_flag) remaining[idx] = {1'b0, period[idx]};
              break;
            end
          end
          if (!r.ok) begin
            r.flag_action = tst_pkg::FLAG_CLEAR;
            r.flag_task = q.task_req;
          end
          scan_pos = (scan_pos + 1) % m;
          expected_q.push_back(r);
        end
        default: begin
          least = 0;
          for (int n = 0; n < NSLOT; n++) begin
            if (owner[n] == 0) continue;
            w = longint'(remaining[n]) - longint'(q.elapsed);
            if (w <= 0) begin
              timer_resp_t e;
              remaining[n] = 0;
              e = blank();
              e.flag_action = tst_pkg::FLAG_SET;
              e.flag_task = owner[n];
              expected_q.push_back(e);
              least = -1;
            end else begin
              remaining[n] = 32'(w);
              if (least == 0 || w < least) least = w;
            end
          end
          r.min_timeout = 32'(least);
          expected_q.push_back(r);
        end
      endcase
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(timer_resp_t g);
      timer_resp_t e;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", 32'(g.last), 32'd0);
        return;
      end
      e = expected_q.pop_front();
      if (g.ok !== e.ok) report_mismatch("ok", 32'(g.ok), 32'(e.ok));
      if (g.result_id !== e.result_id)
        report_mismatch("result_id", 32'(g.result_id), 32'(e.result_id));
      if (g.window_out !== e.window_out)
        report_mismatch("window_out", 32'(g.window_out), 32'(e.window_out));
      if (g.system_out !== e.system_out)
        report_mismatch("system_out", 32'(g.system_out), 32'(e.system_out));
      if (g.callback_out !== e.callback_out)
        report_mismatch("callback_out", g.callback_out, e.callback_out);
      if (g.flag_action !== e.flag_action)
        report_mismatch("flag_action", 32'(g.flag_action), 32'(e.flag_action));
      if (g.flag_task !== e.flag_task)
        report_mismatch("flag_task", 32'(g.flag_task), 32'(e.flag_task));
      if (g.min_timeout !== e.min_timeout)
        report_mismatch("min_timeout", g.min_timeout, e.min_timeout);
      if (g.last !== e.last) report_mismatch("last", 32'(g.last), 32'(e.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [30:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  timer_req_t  drv = '{default: '0};
  timer_resp_t mon;
  int idle_pct = 0;
  int stall_pct = 0;
  timer_scoreboard sb;

  timer_slot_table dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(drv.opcode), .task_req(drv.task_req), .window(drv.window),
    .timer_id(drv.timer_id), .interval(drv.interval), .system_flag(drv.system_flag),
    .callback(drv.callback), .remove_flag(drv.remove_flag), .elapsed(drv.elapsed),
    .out_valid(out_valid), .out_stall(out_stall),
    .ok(mon.ok), .result_id(mon.result_id), .window_out(mon.window_out),
    .system_out(mon.system_out), .callback_out(mon.callback_out),
    .flag_action(mon.flag_action), .flag_task(mon.flag_task),
    .min_timeout(mon.min_timeout), .last(mon.last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) out_stall <= (32'($urandom_range(99)) < stall_pct);

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_input(drv);
      if (out_valid && !out_stall) sb.check_result(mon);
    end
  end

  task send_req(timer_req_t q);
    if (32'($urandom_range(99)) < idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(2)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    drv = q;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task write_default(logic [30:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    sb.dflt_period = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function timer_req_t mk(logic [1:0] op, logic [15:0] tsk, logic [15:0] w,
                          logic [15:0] id, logic [30:0] iv, logic [30:0] el);
    timer_req_t q;
    q = '{default: '0};
    q.opcode = op;
    q.task_req = tsk;
    q.window = w;
    q.timer_id = id;
    q.interval = iv;
    q.elapsed = el;
    q.callback = $urandom;
    q.system_flag = 1'($urandom_range(1));
    q.remove_flag = 1'($urandom_range(1));
    return q;
  endfunction

  // mostly a few tasks and windows so kills and polls find their timers
  function timer_req_t random_req(int set_w);
    timer_req_t q;
    int r;
    int s;
    logic [15:0] tsk;
    logic [15:0] w;
    r = $urandom_range(99);
    tsk = ($urandom_range(9) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(1, 4));
    case ($urandom_range(3))
      0: w = 16'($urandom);
      1: w = 16'h0;
      default: w = 16'($urandom_range(1, 3));
    endcase
    if (r < set_w) begin
      q = mk(tst_pkg::OP_SET, tsk, w, 16'($urandom),
             ($urandom_range(7) == 0) ? 31'($urandom) : 31'($urandom_range(60)), '0);
    end else if (r < set_w + 20) begin
      s = $urandom_range(NSLOT - 1);
      if (sb.owner[s] != 0 && $urandom_range(4) != 0)
        q = mk(tst_pkg::OP_KILL, sb.owner[s], sb.win[s], sb.ident[s], '0, '0);
      else
        q = mk(tst_pkg::OP_KILL, tsk, w, 16'($urandom_range(1, 8)), '0, '0);
    end else if (r < set_w + 50) begin
      q = mk(tst_pkg::OP_POLL, tsk, ($urandom_range(1) == 0) ? 16'h0 : w, '0, '0, '0);
    end else begin
      q = mk(tst_pkg::OP_TICK, tsk, w, '0, '0,
             ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(40)));
    end
    return q;
  endfunction

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    sb = new();
    sb.clear_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty tick, id rules, task zero, expiry, poll filter, shrink
    send_req(mk(tst_pkg::OP_TICK, 16'd1, 16'd0, 16'd0, '0, '0));
    send_req(mk(tst_pkg::OP_SET, 16'd1, 16'd0, 16'd9, '0, '0));
    send_req(mk(tst_pkg::OP_SET, 16'd1, 16'd7, 16'd0, 31'd10, '0));
    send_req(mk(tst_pkg::OP_SET, 16'hFFFF, 16'hFFFF, 16'hFFFF, 31'h7FFFFFFF, '0));
    send_req(mk(tst_pkg::OP_SET, 16'd0, 16'd3, 16'd3, 31'd5, '0));
    send_req(mk(tst_pkg::OP_KILL, 16'd0, 16'd0, 16'd1, '0, '0));
    send_req(mk(tst_pkg::OP_POLL, 16'd0, 16'd0, '0, '0, '0));
    send_req(mk(tst_pkg::OP_POLL, 16'd1, 16'd0, '0, '0, '0));
    send_req(mk(tst_pkg::OP_TICK, 16'd1, 16'd0, '0, '0, 31'd5));
    send_req(mk(tst_pkg::OP_TICK, 16'd1, 16'd0, '0, '0, 31'd20));
    send_req(mk(tst_pkg::OP_POLL, 16'd1, 16'd7, '0, '0, '0));
    send_req(mk(tst_pkg::OP_POLL, 16'd1, 16'd0, '0, '0, '0));
    send_req(mk(tst_pkg::OP_POLL, 16'd1, 16'd0, '0, '0, '0));
    send_req(mk(tst_pkg::OP_KILL, 16'd1, 16'd7, 16'd5, '0, '0));
    send_req(mk(tst_pkg::OP_KILL, 16'd1, 16'd7, 16'd0, '0, '0));
    send_req(mk(tst_pkg::OP_KILL, 16'hFFFF, 16'hFFFF, 16'hFFFF, '0, '0));
    send_req(mk(tst_pkg::OP_POLL, 16'd1, 16'd0, '0, '0, '0));
    send_req(mk(tst_pkg::OP_TICK, 16'd2, 16'd0, '0, '0, 31'h7FFFFFFF));
    send_req(mk(tst_pkg::OP_KILL, 16'd1, 16'd0, 16'd1, '0, '0));
    for (int i = 0; i < 40; i++) send_req(random_req(35));
    drain();

    // zero default: new timers set without an interval expire at once; also fill the table
    write_default(31'd0);
    idle_pct = 67;
    for (int i = 0; i < 50; i++) send_req(random_req(90));
    for (int i = 0; i < 10; i++) send_req(random_req(35));
    drain();

    write_default(31'h7FFFFFFF);
    idle_pct = 0;
    stall_pct = 67;
    for (int i = 0; i < 50; i++) send_req(random_req(35));
    drain();

    write_default(31'd1);
    idle_pct = 26;
    stall_pct = 26;
    for (int i = 0; i < 30; i++) send_req(random_req(30));
    drain();

    write_default(31'($urandom_range(1, 100)));
    for (int i = 0; i < 30; i++) send_req(random_req(35));
    drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
